// ----- rtl/sbpc_pkg.sv -----
// Shared constants, types and tables of the spectrum band peak color core.
package sbpc_pkg;

	// Frame sizing
	localparam int MAX_FRAME = 4096;
	localparam int CNT_W     = $clog2(MAX_FRAME);
	localparam int HALF_MAX  = MAX_FRAME / 2;

	// Field and register widths
	localparam int LEN_W   = 13;
	localparam int EDGE_W  = 12;
	localparam int IDX_W   = 11;
	localparam int LVL_W   = 3;
	localparam int PART_W  = 32;
	localparam int POW_W   = 2 * PART_W;
	localparam int NBANDS  = 3;
	localparam int BAND_W  = 2;

	// Common compare width for bin index, half length and band edges
	localparam int CMP_A = (CNT_W > EDGE_W) ? CNT_W : EDGE_W;
	localparam int CMP_W = (CMP_A > LEN_W - 1) ? CMP_A : LEN_W - 1;

	// Level thresholds: power * 15625 >= (t * n)^2 * 2^26
	localparam int NUM_LEVELS  = 7;
	localparam int K_W         = 3;
	localparam int THR_W       = 7;
	localparam int SCALE_W     = 14;
	localparam logic [SCALE_W-1:0] SCALE_MUL = 14'd15625;
	localparam int SCALE_SHIFT = 26;
	localparam int PROD_W      = SCALE_SHIFT + SCALE_W;
	localparam int SCALED_W    = PROD_W + 1;
	localparam int TN_W        = THR_W + LEN_W;
	localparam int SQ_W        = 2 * TN_W;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	// Configuration register index
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	typedef enum logic [1:0] {
		REG_FRAME_LENGTH = 2'd0,
		REG_BASS_EDGE    = 2'd1,
		REG_TREBLE_EDGE  = 2'd2
	} reg_idx_t;

	typedef enum logic [BAND_W-1:0] {
		BAND_BASS   = 2'd0,
		BAND_MID    = 2'd1,
		BAND_TREBLE = 2'd2
	} band_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCALE,
		BK_THRESH,
		BK_SQUARE,
		BK_COMPARE,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [LEN_W-1:0]  frame_length;
		logic [EDGE_W-1:0] bass_edge_bin;
		logic [EDGE_W-1:0] treble_edge_bin;
	} cfg_t;

	// One finished frame: per band the power to grade and the peak bin
	typedef struct packed {
		logic [NBANDS-1:0][POW_W-1:0] power;
		logic [NBANDS-1:0][IDX_W-1:0] index;
	} peak_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Amplitude thresholds in thousandths, one per level step
	function automatic logic [THR_W-1:0] level_thousandths(input logic [K_W-1:0] k);
		logic [THR_W-1:0] t;
		case (k)
			3'd0:    t = 7'd10;
			3'd1:    t = 7'd25;
			3'd2:    t = 7'd40;
			3'd3:    t = 7'd55;
			3'd4:    t = 7'd70;
			3'd5:    t = 7'd85;
			3'd6:    t = 7'd100;
			default: t = 7'd0;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/sbpc_front.sv -----
// Front part: bin counting, band sorting, power and running per-band peaks.
module sbpc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sbpc_pkg::cfg_t                        cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [sbpc_pkg::PART_W-1:0]    bin_real,
	input  logic signed [sbpc_pkg::PART_W-1:0]    bin_imag,
	input  logic                                  frame_end,
	output logic                                  push,
	output sbpc_pkg::peak_entry_t                 push_data,
	input  sbpc_pkg::q_status_t                   q_status
);

	localparam int CNT_W  = sbpc_pkg::CNT_W;
	localparam int CMP_W  = sbpc_pkg::CMP_W;
	localparam int IDX_W  = sbpc_pkg::IDX_W;
	localparam int POW_W  = sbpc_pkg::POW_W;
	localparam int NBANDS = sbpc_pkg::NBANDS;
	localparam int LEN_W  = sbpc_pkg::LEN_W;

	logic                     advance;
	logic                     accept;
	logic [CNT_W-1:0]         bin_count_q;
	logic [CMP_W-1:0]         half_len;
	logic [CMP_W-1:0]         idx_ext;
	logic                     treat;
	sbpc_pkg::band_t          band;
	logic signed [POW_W-1:0]  re_sq;
	logic signed [POW_W-1:0]  im_sq;

	logic                     valid_s1;
	logic [POW_W-1:0]         re_sq_s1;
	logic [POW_W-1:0]         im_sq_s1;
	logic [IDX_W-1:0]         idx_s1;
	sbpc_pkg::band_t          band_s1;
	logic                     treat_s1;
	logic                     end_s1;

	logic                     valid_s2;
	logic [POW_W-1:0]         power_s2;
	logic [IDX_W-1:0]         idx_s2;
	sbpc_pkg::band_t          band_s2;
	logic                     treat_s2;
	logic                     end_s2;

	logic [NBANDS-1:0][POW_W-1:0] peak_pow_q;
	logic [NBANDS-1:0][IDX_W-1:0] peak_idx_q;
	logic [NBANDS-1:0]            peak_val_q;
	logic [POW_W-1:0]             dc_pow_q;

	logic [NBANDS-1:0][POW_W-1:0] nxt_pow;
	logic [NBANDS-1:0][IDX_W-1:0] nxt_idx;
	logic [NBANDS-1:0]            nxt_val;
	logic [POW_W-1:0]             nxt_dc;

	// Stall only when a frame result cannot enter the queue
	assign advance  = !(valid_s2 && end_s2 && q_status.full);
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// Half the frame, capped at half the largest supported frame
	always_comb begin
		half_len = CMP_W'(cfg.frame_length[LEN_W-1:1]);
		if (half_len > CMP_W'(sbpc_pkg::HALF_MAX)) begin
			half_len = CMP_W'(sbpc_pkg::HALF_MAX);
		end
	end

	assign idx_ext = CMP_W'(bin_count_q);
	assign treat   = idx_ext < half_len;

	always_comb begin
		if (idx_ext < CMP_W'(cfg.bass_edge_bin)) begin
			band = sbpc_pkg::BAND_BASS;
		end else if (idx_ext < CMP_W'(cfg.treble_edge_bin)) begin
			band = sbpc_pkg::BAND_MID;
		end else begin
			band = sbpc_pkg::BAND_TREBLE;
		end
	end

	assign re_sq = POW_W'(bin_real) * POW_W'(bin_real);
	assign im_sq = POW_W'(bin_imag) * POW_W'(bin_imag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				bin_count_q <= '0;
			end else if (bin_count_q != CNT_W'(sbpc_pkg::MAX_FRAME - 1)) begin
				bin_count_q <= bin_count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			re_sq_s1 <= $unsigned(re_sq);
			im_sq_s1 <= $unsigned(im_sq);
			idx_s1   <= bin_count_q[IDX_W-1:0];
			band_s1  <= band;
			treat_s1 <= treat;
			end_s1   <= frame_end;
			power_s2 <= re_sq_s1 + im_sq_s1;
			idx_s2   <= idx_s1;
			band_s2  <= band_s1;
			treat_s2 <= treat_s1;
			end_s2   <= end_s1;
		end
	end

	// Strictly larger replaces: the earliest bin keeps a tie
	always_comb begin
		nxt_pow = peak_pow_q;
		nxt_idx = peak_idx_q;
		nxt_val = peak_val_q;
		nxt_dc  = dc_pow_q;
		if (valid_s2 && treat_s2) begin
			if (idx_s2 == '0) begin
				nxt_dc = power_s2;
			end
			if (!peak_val_q[band_s2] || power_s2 > peak_pow_q[band_s2]) begin
				nxt_pow[band_s2] = power_s2;
				nxt_idx[band_s2] = idx_s2;
				nxt_val[band_s2] = 1'b1;
			end
		end
	end

	// Empty bands fall back to bin 0
	always_comb begin
		for (int b = 0; b < NBANDS; b++) begin
			push_data.power[b] = nxt_val[b] ? nxt_pow[b] : nxt_dc;
			push_data.index[b] = nxt_val[b] ? nxt_idx[b] : '0;
		end
	end

	assign push = advance && valid_s2 && end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_pow_q <= '0;
			peak_idx_q <= '0;
			peak_val_q <= '0;
			dc_pow_q   <= '0;
		end else if (advance && valid_s2) begin
			if (end_s2) begin
				peak_pow_q <= '0;
				peak_idx_q <= '0;
				peak_val_q <= '0;
				dc_pow_q   <= '0;
			end else begin
				peak_pow_q <= nxt_pow;
				peak_idx_q <= nxt_idx;
				peak_val_q <= nxt_val;
				dc_pow_q   <= nxt_dc;
			end
		end
	end

endmodule

// ----- rtl/sbpc_queue.sv -----
// Two-entry queue of finished frames between the front and back parts.
module sbpc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sbpc_pkg::peak_entry_t push_data,
	input  logic                  pop,
	output sbpc_pkg::peak_entry_t pop_data,
	output sbpc_pkg::q_status_t   status
);

	localparam int QPTR_W = sbpc_pkg::QPTR_W;
	localparam int QCNT_W = sbpc_pkg::QCNT_W;

	sbpc_pkg::peak_entry_t entry_q [sbpc_pkg::Q_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;

	assign status.full  = count_q == QCNT_W'(sbpc_pkg::Q_DEPTH);
	assign status.empty = count_q == '0;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/sbpc_back.sv -----
// Back part: grades each band's power against the level thresholds and holds the result.
module sbpc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sbpc_pkg::cfg_t               cfg,
	input  sbpc_pkg::q_status_t          q_status,
	input  sbpc_pkg::peak_entry_t        q_data,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sbpc_pkg::LVL_W-1:0]   bass_level,
	output logic [sbpc_pkg::LVL_W-1:0]   mid_level,
	output logic [sbpc_pkg::LVL_W-1:0]   treble_level,
	output logic [sbpc_pkg::IDX_W-1:0]   bass_peak_bin,
	output logic [sbpc_pkg::IDX_W-1:0]   mid_peak_bin,
	output logic [sbpc_pkg::IDX_W-1:0]   treble_peak_bin
);

	localparam int NBANDS      = sbpc_pkg::NBANDS;
	localparam int BAND_W      = sbpc_pkg::BAND_W;
	localparam int POW_W       = sbpc_pkg::POW_W;
	localparam int LVL_W       = sbpc_pkg::LVL_W;
	localparam int K_W         = sbpc_pkg::K_W;
	localparam int SHIFT       = sbpc_pkg::SCALE_SHIFT;
	localparam int PROD_W      = sbpc_pkg::PROD_W;
	localparam int SCALED_W    = sbpc_pkg::SCALED_W;
	localparam int SCALE_W     = sbpc_pkg::SCALE_W;
	localparam int TN_W        = sbpc_pkg::TN_W;
	localparam int SQ_W        = sbpc_pkg::SQ_W;

	sbpc_pkg::back_state_t state_q;
	sbpc_pkg::back_state_t state_nxt;

	sbpc_pkg::peak_entry_t           ent_q;
	logic [BAND_W-1:0]               band_q;
	logic                            part_q;
	logic [K_W-1:0]                  k_q;
	logic [PROD_W-1:0]               hi_prod_q;
	logic [NBANDS-1:0][SCALED_W-1:0] scaled_q;
	logic [TN_W-1:0]                 tn_q;
	logic [SQ_W-1:0]                 sq_q;
	logic [NBANDS-1:0][LVL_W-1:0]    level_q;
	logic                            out_valid_q;

	logic [POW_W-1:0]   cur_pow;
	logic               cur_big;
	logic [PROD_W-1:0]  lo_prod;
	logic               last_band;
	logic               last_k;
	logic               out_load;

	assign cur_pow   = ent_q.power[band_q];
	// Powers at or above 2^(2*SHIFT) pass every threshold
	assign cur_big   = |cur_pow[POW_W-1:2*SHIFT];
	assign lo_prod   = PROD_W'(cur_pow[SHIFT-1:0]) * PROD_W'(sbpc_pkg::SCALE_MUL);
	assign last_band = band_q == BAND_W'(NBANDS - 1);
	assign last_k    = k_q == K_W'(sbpc_pkg::NUM_LEVELS - 1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sbpc_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					state_nxt = sbpc_pkg::BK_SCALE;
				end
			end
			sbpc_pkg::BK_SCALE: begin
				if (part_q && last_band) begin
					state_nxt = sbpc_pkg::BK_THRESH;
				end
			end
			sbpc_pkg::BK_THRESH:  state_nxt = sbpc_pkg::BK_SQUARE;
			sbpc_pkg::BK_SQUARE:  state_nxt = sbpc_pkg::BK_COMPARE;
			sbpc_pkg::BK_COMPARE: begin
				state_nxt = last_k ? sbpc_pkg::BK_OUT : sbpc_pkg::BK_THRESH;
			end
			sbpc_pkg::BK_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = sbpc_pkg::BK_IDLE;
				end
			end
			default: state_nxt = sbpc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			sbpc_pkg::BK_IDLE: pop      = !q_status.empty;
			sbpc_pkg::BK_OUT:  out_load = !out_valid_q || out_ready;
			default: begin
				pop      = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbpc_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sbpc_pkg::BK_IDLE: begin
				ent_q   <= q_data;
				band_q  <= '0;
				part_q  <= 1'b0;
				k_q     <= '0;
				level_q <= '0;
			end
			sbpc_pkg::BK_SCALE: begin
				part_q <= !part_q;
				if (!part_q) begin
					hi_prod_q <= PROD_W'(cur_pow[2*SHIFT-1:SHIFT]) *
					             PROD_W'(sbpc_pkg::SCALE_MUL);
				end else begin
					band_q <= band_q + BAND_W'(1);
					if (cur_big) begin
						scaled_q[band_q] <= '1;
					end else begin
						scaled_q[band_q] <= SCALED_W'(hi_prod_q) +
						                    SCALED_W'(lo_prod[PROD_W-1:PROD_W-SCALE_W]);
					end
				end
			end
			sbpc_pkg::BK_THRESH: begin
				tn_q <= TN_W'(sbpc_pkg::level_thousandths(k_q)) * TN_W'(cfg.frame_length);
			end
			sbpc_pkg::BK_SQUARE: begin
				sq_q <= SQ_W'(tn_q) * SQ_W'(tn_q);
			end
			sbpc_pkg::BK_COMPARE: begin
				k_q <= k_q + K_W'(1);
				for (int b = 0; b < NBANDS; b++) begin
					if (scaled_q[b] >= SCALED_W'(sq_q)) begin
						level_q[b] <= level_q[b] + LVL_W'(1);
					end
				end
			end
			default: begin
				band_q <= band_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bass_level      <= level_q[sbpc_pkg::BAND_BASS];
			mid_level       <= level_q[sbpc_pkg::BAND_MID];
			treble_level    <= level_q[sbpc_pkg::BAND_TREBLE];
			bass_peak_bin   <= ent_q.index[sbpc_pkg::BAND_BASS];
			mid_peak_bin    <= ent_q.index[sbpc_pkg::BAND_MID];
			treble_peak_bin <= ent_q.index[sbpc_pkg::BAND_TREBLE];
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/spectrum_band_peak_color_core.sv -----
// Top level of the spectrum band peak color core: config registers, front, queue, back.
//
// The core takes one frame of complex spectrum bins (signed Q15.16 real and
// imaginary parts), one bin per word on the slave stream, with tlast on the
// last bin. Only bins below half the frame length are used (never beyond
// bin 2047). Each used bin goes to the bass band (index below
// bass_edge_bin), the mid band (below treble_edge_bin) or the treble band;
// per band the bin of largest squared magnitude is kept, the earliest one
// winning a tie. After the tlast bin one word leaves on the master stream
// with each band's peak bin and a color level 0 (blue) to 7 (white): the
// count of amplitude thresholds 0.010 .. 0.100 of full scale, scaled by
// frame_length, that the peak reaches. An empty band reports bin 0 graded
// by the power of bin 0. Bins are taken one per cycle unless a full queue
// holds up a finished frame; squares and then power are registered ahead
// of the running peak compare. The grading unit takes one frame at a time
// (one shared multiplier pair walks the seven thresholds for all three
// bands), and a two-frame queue in between lets bins keep flowing while
// earlier frames are graded, until it fills and the input stalls.
// Write the registers only while the core is idle.
module spectrum_band_peak_color_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [sbpc_pkg::DATA_W-1:0]   pwdata,
	output logic [sbpc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// Bin stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,  // bin_real[31:0], bin_imag[63:32]
	input  logic                          s_tlast,  // frame_end
	// Result stream out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [47:0]                   m_tdata   // bass_level[2:0], mid_level[5:3],
	                                                // treble_level[8:6], bass_peak_bin[19:9],
	                                                // mid_peak_bin[30:20],
	                                                // treble_peak_bin[41:31], zero[47:42]
);

	localparam int LEN_W  = sbpc_pkg::LEN_W;
	localparam int EDGE_W = sbpc_pkg::EDGE_W;
	localparam int LVL_W  = sbpc_pkg::LVL_W;
	localparam int IDX_W  = sbpc_pkg::IDX_W;
	localparam int PART_W = sbpc_pkg::PART_W;
	localparam int DATA_W = sbpc_pkg::DATA_W;

	sbpc_pkg::cfg_t        cfg_q;
	sbpc_pkg::reg_idx_t    reg_idx;
	logic                  cfg_write;

	logic                  push;
	logic                  pop;
	sbpc_pkg::peak_entry_t push_data;
	sbpc_pkg::peak_entry_t pop_data;
	sbpc_pkg::q_status_t   q_status;

	logic [LVL_W-1:0]      bass_level;
	logic [LVL_W-1:0]      mid_level;
	logic [LVL_W-1:0]      treble_level;
	logic [IDX_W-1:0]      bass_peak_bin;
	logic [IDX_W-1:0]      mid_peak_bin;
	logic [IDX_W-1:0]      treble_peak_bin;

	// Registers sit on word addresses; low address bits are ignored
	assign reg_idx   = sbpc_pkg::reg_idx_t'(paddr[3:2]);
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_length    <= LEN_W'(2048);
			cfg_q.bass_edge_bin   <= EDGE_W'(12);
			cfg_q.treble_edge_bin <= EDGE_W'(93);
		end else if (cfg_write) begin
			case (reg_idx)
				sbpc_pkg::REG_FRAME_LENGTH: cfg_q.frame_length    <= pwdata[LEN_W-1:0];
				sbpc_pkg::REG_BASS_EDGE:    cfg_q.bass_edge_bin   <= pwdata[EDGE_W-1:0];
				sbpc_pkg::REG_TREBLE_EDGE:  cfg_q.treble_edge_bin <= pwdata[EDGE_W-1:0];
				default:                    cfg_q                 <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sbpc_pkg::REG_FRAME_LENGTH: prdata = DATA_W'(cfg_q.frame_length);
			sbpc_pkg::REG_BASS_EDGE:    prdata = DATA_W'(cfg_q.bass_edge_bin);
			sbpc_pkg::REG_TREBLE_EDGE:  prdata = DATA_W'(cfg_q.treble_edge_bin);
			default:                    prdata = '0;
		endcase
	end

	// Front: one bin per cycle unless stalled by a full queue, running peaks, frame summary into the queue
	sbpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.bin_real  ($signed(s_tdata[PART_W-1:0])),
		.bin_imag  ($signed(s_tdata[2*PART_W-1:PART_W])),
		.frame_end (s_tlast),
		.push      (push),
		.push_data (push_data),
		.q_status  (q_status)
	);

	// Decouple bin intake from grading
	sbpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// Back: grade each band and hold the result word until taken
	sbpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_status        (q_status),
		.q_data          (pop_data),
		.pop             (pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.bass_level      (bass_level),
		.mid_level       (mid_level),
		.treble_level    (treble_level),
		.bass_peak_bin   (bass_peak_bin),
		.mid_peak_bin    (mid_peak_bin),
		.treble_peak_bin (treble_peak_bin)
	);

	assign m_tdata = {6'b0, treble_peak_bin, mid_peak_bin, bass_peak_bin,
	                  treble_level, mid_level, bass_level};

endmodule

// ----- test/spectrum_band_peak_color_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the spectrum band peak color core: directed and random bin frames.
module spectrum_band_peak_color_core_tb;
	import sbpc_pkg::*;

	// Cycles to let the grading unit run dry before a register write or the end
	localparam int SETTLE_CYCLES = 60;
	// Upper bound on cycles spent waiting for outstanding frames in one drain
	localparam int DRAIN_GUARD   = 20000;
	localparam int N_PHASES      = 7;
	localparam int PHASE_BINS    = 100;
	localparam int LONG_BINS     = 300;
	localparam int MAX_REPORTS   = 10;
	// One thousandth of full scale for a frame length of 1000
	localparam logic [31:0] MILLI = 32'd65536;

	// Result word, first field (pad) in the highest bits
	typedef struct packed {
		logic [5:0]       pad;
		logic [IDX_W-1:0] treble_peak;
		logic [IDX_W-1:0] mid_peak;
		logic [IDX_W-1:0] bass_peak;
		logic [LVL_W-1:0] treble_lvl;
		logic [LVL_W-1:0] mid_lvl;
		logic [LVL_W-1:0] bass_lvl;
	} color_word_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [63:0]       s_tdata;   // bin_real[31:0], bin_imag[63:32]
	logic              s_tlast;   // frame_end
	logic              m_tvalid;
	logic              m_tready;
	logic [47:0]       m_tdata;   // bass_level, mid_level, treble_level, bass_peak_bin,
	                              // mid_peak_bin, treble_peak_bin, zero pad

	spectrum_band_peak_color_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Register copy and per-frame peak tracking of the predictor
	cfg_t             cfg_mirror;
	logic [CNT_W-1:0] bin_pos;
	logic [IDX_W-1:0] peak_bin [NBANDS];
	logic [POW_W-1:0] peak_pow [NBANDS];
	bit               peak_seen [NBANDS];
	logic [POW_W-1:0] dc_pow;

	// Color words still owed by the core, oldest first
	color_word_t      color_q [$];

	int unsigned mismatches;
	int unsigned bins_sent;
	int unsigned frames_checked;
	int unsigned settings_used;
	int unsigned rx_hold;
	bit          tx_steady;
	bit          rx_steady;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Timeout: %0d color words still owed", color_q.size());
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_peaks();
		bin_pos = '0;
		dc_pow  = '0;
		for (int b = 0; b < NBANDS; b++) begin
			peak_bin[b]  = '0;
			peak_pow[b]  = '0;
			peak_seen[b] = 1'b0;
		end
	endfunction

	// Smallest power that reaches t thousandths of full scale for n bins:
	// ceil(t^2 * n^2 * 2^32 / 10^6), kept exact in a wide vector
	function automatic logic [POW_W-1:0] level_floor(input int unsigned t,
		input logic [LEN_W-1:0] n);
		logic [127:0] num;
		num = (128'(t) * 128'(t) * 128'(n) * 128'(n)) << 26;
		return POW_W'((num + 128'd15624) / 128'd15625);
	endfunction

	// Count the thresholds 10, 25, ..., 100 thousandths that the power reaches
	function automatic logic [LVL_W-1:0] grade(input logic [POW_W-1:0] p);
		logic [LVL_W-1:0] lvl;
		lvl = '0;
		for (int k = 0; k < NUM_LEVELS; k++)
			if (p >= level_floor(10 + 15 * k, cfg_mirror.frame_length))
				lvl++;
		return lvl;
	endfunction

	// An empty band falls back to the power of bin 0 and reports bin 0
	function automatic logic [POW_W-1:0] band_power(input band_t b);
		return peak_seen[b] ? peak_pow[b] : dc_pow;
	endfunction

	function automatic logic [IDX_W-1:0] band_bin(input band_t b);
		return peak_seen[b] ? peak_bin[b] : '0;
	endfunction

	// Advance the peak tracking by one bin; on frame end hand back the color word
	task automatic track_bin(input logic [31:0] re, input logic [31:0] im,
		input logic last, output bit has_word, output color_word_t word);
		int unsigned      half_len;
		int unsigned      pos;
		logic [POW_W-1:0] mag_re;
		logic [POW_W-1:0] mag_im;
		logic [POW_W-1:0] pw;
		band_t            band;
		half_len = cfg_mirror.frame_length / 2;
		if (half_len > HALF_MAX)
			half_len = HALF_MAX;
		pos  = bin_pos;
		word = '0;
		if (pos < half_len) begin
			mag_re = re[31] ? 64'd0 - {32'hFFFF_FFFF, re} : {32'd0, re};
			mag_im = im[31] ? 64'd0 - {32'hFFFF_FFFF, im} : {32'd0, im};
			pw     = mag_re * mag_re + mag_im * mag_im;
			if (pos < cfg_mirror.bass_edge_bin)
				band = BAND_BASS;
			else if (pos < cfg_mirror.treble_edge_bin)
				band = BAND_MID;
			else
				band = BAND_TREBLE;
			if (pos == 0)
				dc_pow = pw;
			// strictly larger only: the earliest bin keeps a tie
			if (!peak_seen[band] || pw > peak_pow[band]) begin
				peak_seen[band] = 1'b1;
				peak_pow[band]  = pw;
				peak_bin[band]  = IDX_W'(pos);
			end
		end
		// hold the bin index at the top once a frame runs too long
		if (bin_pos < MAX_FRAME - 1)
			bin_pos++;
		has_word = last;
		if (last) begin
			word.bass_lvl    = grade(band_power(BAND_BASS));
			word.mid_lvl     = grade(band_power(BAND_MID));
			word.treble_lvl  = grade(band_power(BAND_TREBLE));
			word.bass_peak   = band_bin(BAND_BASS);
			word.mid_peak    = band_bin(BAND_MID);
			word.treble_peak = band_bin(BAND_TREBLE);
			clear_peaks();
		end
	endtask

	// ---------------------------------------------------------------- drivers

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_FRAME_LENGTH: cfg_mirror.frame_length    = value[LEN_W-1:0];
			REG_BASS_EDGE:    cfg_mirror.bass_edge_bin   = value[EDGE_W-1:0];
			REG_TREBLE_EDGE:  cfg_mirror.treble_edge_bin = value[EDGE_W-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned len, input int unsigned bass_edge,
		input int unsigned treble_edge);
		write_reg(REG_FRAME_LENGTH, DATA_W'(len));
		write_reg(REG_BASS_EDGE, DATA_W'(bass_edge));
		write_reg(REG_TREBLE_EDGE, DATA_W'(treble_edge));
		settings_used++;
	endtask

	// Offer one bin after a random gap; valid stays up for a back-to-back word
	task automatic send_bin(input logic [31:0] re, input logic [31:0] im, input logic last);
		int unsigned gap;
		bit          has_word;
		color_word_t word;
		gap = tx_steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {im, re};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bins_sent++;
		track_bin(re, im, last, has_word, word);
		if (has_word)
			color_q.push_back(word);
	endtask

	// Drop valid and wait for every owed color word, giving up at the drain guard
	task automatic drain_results();
		int unsigned guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (color_q.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		@(posedge clk);
	endtask

	// Drain, then let the grading unit finish before touching registers
	task automatic settle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Bin part: full random, near a level threshold, small noise or zero
	function automatic logic [31:0] draw_part();
		int unsigned pick;
		int unsigned t;
		logic [63:0] n;
		logic [63:0] base;
		n    = (cfg_mirror.frame_length == 0) ? 64'd1000 : 64'(cfg_mirror.frame_length);
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return $urandom();
		if (pick < 70) begin
			t = $urandom_range(0, 8);
			t = (t == 0) ? 0 : (t == 8) ? 120 : 10 + 15 * (t - 1);
			base = 64'(t) * n * 64'd65536 / 64'd1000 + 64'($urandom_range(0, 6));
			base = (base > 3) ? base - 3 : base;
			return $urandom_range(0, 1) ? 32'd0 - base[31:0] : base[31:0];
		end
		if (pick < 85)
			return 32'($urandom_range(0, 511)) - 32'd256;
		return 32'd0;
	endfunction

	function automatic logic [EDGE_W-1:0] draw_edge(input int unsigned lim);
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return EDGE_W'(1);
			2:       return EDGE_W'(2048);
			3:       return '1;
			default: return EDGE_W'($urandom_range(0, lim));
		endcase
	endfunction

	// Random frame; some bins repeat the previous one to force ties
	task automatic send_frame(input int unsigned nbins);
		logic [31:0] re;
		logic [31:0] im;
		re = '0;
		im = '0;
		for (int unsigned i = 0; i < nbins; i++) begin
			if (i == 0 || $urandom_range(0, 99) >= 15) begin
				re = draw_part();
				im = ($urandom_range(0, 99) < 40) ? 32'd0 : draw_part();
			end
			send_bin(re, im, i == nbins - 1);
		end
	endtask

	// ---------------------------------------------------------------- checker

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("Mismatch in frame %0d, %s: expected %0d, got %0d",
					frames_checked, name, want, got);
		end
	endfunction

	// Receiver: stall at random or for a requested hold-off, then take one word
	initial begin
		color_word_t got;
		color_word_t want;
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 13);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			if (color_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected color word %h", got);
			end else begin
				want = color_q.pop_front();
				check_field("bass_level", want.bass_lvl, got.bass_lvl);
				check_field("mid_level", want.mid_lvl, got.mid_lvl);
				check_field("treble_level", want.treble_lvl, got.treble_lvl);
				check_field("bass_peak_bin", want.bass_peak, got.bass_peak);
				check_field("mid_peak_bin", want.mid_peak, got.mid_peak);
				check_field("treble_peak_bin", want.treble_peak, got.treble_peak);
				check_field("pad", want.pad, got.pad);
				frames_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Reset settings, full-scale parts and a one-bin frame
	task automatic test_reset_defaults();
		settle();
		send_bin(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_bin(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_bin(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_bin(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_bin(32'h0000_0000, 32'h0000_0000, 1'b1);
	endtask

	// Frame length 1000 puts the thresholds on whole multiples of MILLI:
	// hit several boundaries exactly and some one step below
	task automatic test_level_steps();
		settle();
		configure(1000, 2, 4);
		send_bin(100 * MILLI, 32'd0, 1'b0);
		send_bin(32'd0 - 100 * MILLI, 32'd0, 1'b0);       // tie, earlier bin stays
		send_bin(32'd0, 100 * MILLI - 1, 1'b0);
		send_bin(55 * MILLI, 32'd0, 1'b0);
		send_bin(55 * MILLI, 32'd0, 1'b0);
		send_bin(40 * MILLI, 32'd0 - 40 * MILLI, 1'b1);
		send_bin(10 * MILLI, 32'd0, 1'b0);
		send_bin(10 * MILLI + 1, 32'd0, 1'b0);
		send_bin(10 * MILLI - 1, 32'd0, 1'b0);
		send_bin(32'd0, 32'd0, 1'b0);
		send_bin(85 * MILLI, 32'd0, 1'b0);
		send_bin(70 * MILLI, 32'd0 - 70 * MILLI, 1'b1);
	endtask

	// Odd length, swapped and zero edges, all-in-one-band, lengths zero and one
	task automatic test_empty_bands();
		settle();
		configure(7, 5, 3);
		send_bin(32'h0001_0000, 32'd0, 1'b0);
		send_bin(32'h0020_0000, 32'd0, 1'b0);
		send_bin(32'h0010_0000, 32'h0000_0100, 1'b0);
		send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);     // past half, ignored
		send_bin(32'h8000_0000, 32'd0, 1'b1);
		settle();
		configure(20, 0, 0);
		send_bin(32'h0003_0000, 32'hFFFD_0000, 1'b0);
		send_bin(32'h0004_0000, 32'd0, 1'b1);
		settle();
		configure(20, 0, 4095);
		send_bin(32'd0, 32'h0002_0000, 1'b0);
		send_bin(32'hFFF0_0000, 32'd5, 1'b1);
		settle();
		configure(20, 4095, 4095);
		send_bin(32'h0000_8000, 32'd0, 1'b0);
		send_bin(32'h0000_8000, 32'd0, 1'b1);
		settle();
		configure(0, 12, 93);
		send_bin(32'd0, 32'd0, 1'b1);
		settle();
		configure(1, 12, 93);
		send_bin(32'h7FFF_FFFF, 32'd0, 1'b1);
	endtask

	// Largest frame length: the highest thresholds, one long frame over all bands
	task automatic test_long_length();
		logic [31:0] re;
		logic [31:0] im;
		settle();
		configure(8191, 100, 200);
		for (int unsigned i = 0; i < LONG_BINS; i++) begin
			re = draw_part();
			im = ($urandom_range(0, 1)) ? 32'd0 : draw_part();
			send_bin(re, im, i == LONG_BINS - 1);
		end
		// the next frame must start again from bin 0
		settle();
		configure(4096, 2048, 2048);
		send_frame(5);
	endtask

	// Hold the output for a long stretch while short frames keep coming
	task automatic test_output_stall();
		settle();
		configure(16, 2, 5);
		tx_steady = 1'b1;
		rx_hold   = 400;
		for (int f = 0; f < 15; f++)
			send_frame(2);
		tx_steady = 1'b0;
		settle();
	endtask

	// Random register settings, each with about PHASE_BINS bins of random frames
	task automatic test_random_phases();
		int unsigned len;
		int unsigned half_len;
		int unsigned max_bins;
		int unsigned phase_bins;
		bit          paused;
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			if (p == 0) begin
				len = 2;
			end else if (p == 1) begin
				len = 4096;
			end else begin
				case ($urandom_range(0, 9))
					0:       len = $urandom_range(0, 1) ? 8191 : $urandom_range(0, 3);
					1, 2, 3: len = $urandom_range(2, 16);
					4, 5:    len = $urandom_range(81, 300);
					default: len = $urandom_range(17, 80);
				endcase
			end
			half_len = (len / 2 > HALF_MAX) ? HALF_MAX : len / 2;
			if (p == 0)
				configure(len, 1, 1);
			else if (p == 1)
				configure(len, 2048, 2048);
			else
				configure(len, draw_edge(half_len + 2), draw_edge(half_len + 2));
			tx_steady = (p % 3) != 0;
			rx_steady = (p % 3) == 2;
			max_bins  = (half_len + 4 < 60) ? half_len + 4 : 60;
			phase_bins = 0;
			paused     = 1'b0;
			while (phase_bins < PHASE_BINS) begin
				len = $urandom_range(1, max_bins);
				send_frame(len);
				phase_bins += len;
				// pause the input once until everything owed has come back
				if (!paused && phase_bins >= PHASE_BINS / 2) begin
					paused = 1'b1;
					drain_results();
				end
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		mismatches     = 0;
		bins_sent      = 0;
		frames_checked = 0;
		settings_used  = 1;
		rx_hold        = 0;
		tx_steady      = 1'b0;
		rx_steady      = 1'b0;
		cfg_mirror.frame_length    = LEN_W'(2048);
		cfg_mirror.bass_edge_bin   = EDGE_W'(12);
		cfg_mirror.treble_edge_bin = EDGE_W'(93);
		clear_peaks();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_level_steps();
		test_empty_bands();
		test_long_length();
		test_output_stall();
		test_random_phases();

		settle();
		if (color_q.size() != 0) begin
			$display("%0d color words never arrived", color_q.size());
			mismatches += color_q.size();
		end
		$display("Sent %0d bins, checked %0d color words over %0d register settings",
			bins_sent, frames_checked, settings_used);
		$display("Covered level boundaries, empty and swapped bands, long frame lengths, stalls");
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
